// ===== rtl/gng_pkg.sv =====
package gng_pkg;

    localparam int unsigned SEED_W      = 31;
    localparam int unsigned CFG_W       = 32;
    localparam int unsigned SAMPLE_W    = 40;
    localparam int unsigned MUL_W       = 32;
    localparam int unsigned FRAC_SHIFT  = 31;
    localparam int unsigned SUM_COUNT_D = 12;

    localparam logic [MUL_W-1:0]  LCG_MUL = 32'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD = 31'd12345;

    localparam logic [CFG_W-1:0] SIGMA_RESET = 32'd65536;
    localparam logic [CFG_W-1:0] MEAN_RESET  = 32'd0;

    localparam logic REG_SIGMA = 1'b0;
    localparam logic REG_MEAN  = 1'b1;

    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_RESEED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_LAST,
        ST_DEV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCALE,
        ST_EMIT
    } gng_state_t;

    typedef struct packed {
        logic load_seed;
        logic start;
        logic lcg_step;
        logic add_seed;
        logic dev;
        logic mul_lo;
        logic mul_hi;
        logic scale;
        logic emit;
    } gng_cmd_t;

    typedef struct packed {
        logic out_busy;
    } gng_stat_t;

endpackage

// ===== rtl/gng_ctrl.sv =====
module gng_ctrl #(
    parameter int unsigned SUM_COUNT = gng_pkg::SUM_COUNT_D
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              kind,
    input  gng_pkg::gng_stat_t stat,
    output gng_pkg::gng_cmd_t  cmd
);
    import gng_pkg::*;

    localparam int unsigned CNT_W = (SUM_COUNT > 1) ? $clog2(SUM_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_COUNT - 1);

    gng_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             s_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (kind == KIND_RESEED) begin
                        cmd.load_seed = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                cmd.lcg_step = 1'b1;
                cmd.add_seed = (cnt_reg != '0);
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                cmd.add_seed = 1'b1;
                state_next   = ST_DEV;
            end
            ST_DEV: begin
                cmd.dev    = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_draw_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (kind == KIND_DRAW) |=> state_reg == ST_RUN)
        else $error("draw beat did not start the generator run");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && (cnt_reg == CNT_LAST) |=> state_reg == ST_LAST)
        else $error("generator run did not end after the last step");

    a_mul_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_hi |-> $past(cmd.mul_lo))
        else $error("upper partial product without lower partial product");

endmodule

// ===== rtl/gng_dp.sv =====
module gng_dp #(
    parameter int unsigned SUM_COUNT = gng_pkg::SUM_COUNT_D
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_addr,
    input  logic [gng_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic [gng_pkg::SEED_W-1:0]     new_seed,
    input  gng_pkg::gng_cmd_t              cmd,
    output gng_pkg::gng_stat_t             stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gng_pkg::SAMPLE_W-1:0]   sample
);
    import gng_pkg::*;

    localparam int unsigned SUM_W  = SEED_W + $clog2(SUM_COUNT);
    localparam int unsigned MAG_W  = (SUM_W > MUL_W + 1) ? SUM_W : MUL_W + 1;
    localparam int unsigned PROD_W = MAG_W + MUL_W;
    localparam logic [SUM_W-1:0] OFFSET = SUM_W'(SUM_COUNT) << 30;

    logic [CFG_W-1:0]    sigma_reg, sigma_next;
    logic [CFG_W-1:0]    mean_reg, mean_next;
    logic [SEED_W-1:0]   seed_reg, seed_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SAMPLE_W-1:0] scaled_reg, scaled_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [2*MUL_W-1:0]  mul_p;
    logic [SEED_W-1:0]   lcg_val;
    logic [SAMPLE_W-1:0] q_ext;
    logic                rem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_reg    <= SIGMA_RESET;
            mean_reg     <= MEAN_RESET;
            seed_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            sigma_reg    <= sigma_next;
            mean_reg     <= mean_next;
            seed_reg     <= seed_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg    <= sum_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        scaled_reg <= scaled_next;
        sample_reg <= sample_next;
    end

    // One shared multiplier serves the generator steps and both partial products.
    always_comb begin
        mul_a = {1'b0, seed_reg};
        mul_b = LCG_MUL;
        if (cmd.mul_lo) begin
            mul_a = mag_reg[MUL_W-1:0];
            mul_b = sigma_reg;
        end else if (cmd.mul_hi) begin
            mul_a = {{(2*MUL_W-MAG_W){1'b0}}, mag_reg[MAG_W-1:MUL_W]};
            mul_b = sigma_reg;
        end
    end

    assign mul_p   = mul_a * mul_b;
    assign lcg_val = mul_p[SEED_W-1:0] + LCG_ADD;
    assign q_ext   = SAMPLE_W'(prod_reg[PROD_W-1:FRAC_SHIFT]);
    assign rem     = |prod_reg[FRAC_SHIFT-1:0];

    always_comb begin
        sigma_next    = sigma_reg;
        mean_next     = mean_reg;
        seed_next     = seed_reg;
        sum_next      = sum_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        prod_next     = prod_reg;
        scaled_next   = scaled_reg;
        sample_next   = sample_reg;
        m_tvalid_next = m_tvalid_reg;

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SIGMA: sigma_next = cfg_wdata;
                REG_MEAN:  mean_next  = cfg_wdata;
                default:   sigma_next = sigma_reg;
            endcase
        end

        if (cmd.load_seed) begin
            seed_next = new_seed;
        end
        if (cmd.start) begin
            sum_next = '0;
        end
        if (cmd.lcg_step) begin
            seed_next = lcg_val;
        end
        if (cmd.add_seed) begin
            sum_next = sum_reg + SUM_W'(seed_reg);
        end
        if (cmd.dev) begin
            neg_next = (sum_reg < OFFSET);
            mag_next = (sum_reg < OFFSET) ? MAG_W'(OFFSET - sum_reg)
                                          : MAG_W'(sum_reg - OFFSET);
        end
        if (cmd.mul_lo) begin
            prod_next = PROD_W'(mul_p);
        end
        if (cmd.mul_hi) begin
            prod_next = prod_reg + (PROD_W'(mul_p) << MUL_W);
        end
        if (cmd.scale) begin
            // Floor of a negative quotient: negate and step down when bits were dropped.
            scaled_next = neg_reg ? (~q_ext + SAMPLE_W'(!rem)) : q_ext;
        end

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.emit) begin
            sample_next   = scaled_reg + {{(SAMPLE_W-CFG_W){mean_reg[CFG_W-1]}}, mean_reg};
            m_tvalid_next = 1'b1;
        end
    end

    assign stat.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign sample        = sample_reg;

    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(cmd.emit))
        else $error("result beat raised without an emit command");

    a_emit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && !stat.out_busy |=> m_tvalid_reg)
        else $error("emitted result did not reach the output register");

endmodule

// ===== rtl/gaussian_noise_generator.sv =====
// Approximate Gaussian sample generator (central limit sum of LCG uniforms).
// Input stream s_*: s_tuser selects the beat kind, 0 draws one sample and
// 1 loads s_tdata[30:0] as the new generator seed; a reseed beat gives no
// result. Result stream m_*: m_tdata carries one signed Q24.16 sample.
// The configuration port writes sigma (index 0, unsigned Q16.16) and the
// mean (index 1, signed Q16.16); write them only while no draw is in flight.
// A single 32x32 multiplier runs the SUM_COUNT dependent generator steps
// (twelve by default), then the two partial products of the scaling. A
// reseed beat leaves the block ready for the next beat. s_tready is high
// only while no draw is in progress, so one draw is in flight at a time
// and a new draw is not accepted before the last one has been emitted.
// The output register holds a finished sample while m_tready is low; the
// next draw may be accepted and computed meanwhile and waits for the
// register to empty. Reset clears the seed to zero, sigma to 1.0 and the
// mean to 0, and empties the output register.
module gaussian_noise_generator #(
    parameter int unsigned SUM_COUNT = gng_pkg::SUM_COUNT_D
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,  // new_seed[30:0], zero bit 31
    input  logic                         s_tuser,  // kind
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gng_pkg::SAMPLE_W-1:0] m_tdata,  // sample[39:0]
    input  logic                         cfg_wr_en,
    input  logic                         cfg_addr,
    input  logic [gng_pkg::CFG_W-1:0]    cfg_wdata
);
    import gng_pkg::*;

    gng_cmd_t  cmd;
    gng_stat_t stat;

    gng_ctrl #(
        .SUM_COUNT (SUM_COUNT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    gng_dp #(
        .SUM_COUNT (SUM_COUNT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .new_seed  (s_tdata[SEED_W-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .sample    (m_tdata)
    );

endmodule

// ===== dv/tb_gaussian_noise_generator.sv =====
`timescale 1ns / 100ps

module tb_gaussian_noise_generator;
    import gng_pkg::*;

    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned SETTLE_CYCLES = 2 * SUM_COUNT_D + 10;
    localparam int unsigned PHASES = 7;
    localparam int unsigned BEATS_PER_PHASE = 200;

    class noise_scoreboard;
        logic [SEED_W-1:0]   seed;
        logic [CFG_W-1:0]    sigma;
        logic [CFG_W-1:0]    mean;
        logic [SAMPLE_W-1:0] expected_samples[$];
        int unsigned         mismatches;

        function new();
            seed       = '0;
            sigma      = SIGMA_RESET;
            mean       = MEAN_RESET;
            mismatches = 0;
        endfunction

        function void set_config(logic [CFG_W-1:0] sigma_val, logic [CFG_W-1:0] mean_val);
            sigma = sigma_val;
            mean  = mean_val;
        endfunction

        function int unsigned pending();
            return expected_samples.size();
        endfunction

        // Central limit sum of the generator states, scaled by sigma with
        // a floor division by 2^31, then offset by the mean.
        function logic [SAMPLE_W-1:0] draw_sample();
            logic [63:0]        step_val;
            logic [63:0]        total;
            logic signed [79:0] dev;
            logic signed [79:0] scaled;
            total = '0;
            for (int k = 0; k < SUM_COUNT_D; k++) begin
                step_val = {33'd0, seed} * {32'd0, LCG_MUL} + {33'd0, LCG_ADD};
                seed     = step_val[SEED_W-1:0];
                total    = total + {33'd0, seed};
            end
            dev    = 80'(total);
            dev    = dev - (80'(SUM_COUNT_D) << 30);
            scaled = dev * $signed({48'd0, sigma});
            scaled = scaled >>> FRAC_SHIFT;
            scaled = scaled + {{48{mean[CFG_W-1]}}, mean};
            return scaled[SAMPLE_W-1:0];
        endfunction

        function void note_beat(logic kind, logic [SEED_W-1:0] new_seed);
            if (kind == KIND_RESEED) begin
                seed = new_seed;
            end else begin
                expected_samples.push_back(draw_sample());
            end
        endfunction

        function void check_sample(logic [SAMPLE_W-1:0] actual);
            logic [SAMPLE_W-1:0] want;
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected sample beat: actual %h", actual);
                end
            end else begin
                want = expected_samples.pop_front();
                if (actual !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Sample mismatch: expected %h, actual %h", want, actual);
                    end
                end
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_tdata;
    logic                cfg_wr_en;
    logic                cfg_addr;
    logic [CFG_W-1:0]    cfg_wdata;

    noise_scoreboard scb = new();
    logic            calm;
    int unsigned     stall_left = 0;
    int unsigned     quiet_cycles = 0;

    gaussian_noise_generator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 199) == 0) begin
            stall_left <= $urandom_range(20, 40);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                scb.note_beat(s_tuser, s_tdata[SEED_W-1:0]);
            end
            if (m_tvalid && m_tready) begin
                scb.check_sample(m_tdata);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("** gaussian_noise_generator: FAILED **");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_beat(input logic kind, input logic [SEED_W-1:0] seed_val);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, seed_val};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        while (!calm && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_random_beat();
        logic              kind;
        logic [SEED_W-1:0] seed_val;
        kind = ($urandom_range(0, 99) < 25) ? KIND_RESEED : KIND_DRAW;
        case ($urandom_range(0, 9))
            0:       seed_val = '0;
            1:       seed_val = '1;
            default: seed_val = SEED_W'($urandom());
        endcase
        send_beat(kind, seed_val);
    endtask

    task automatic drain();
        @(posedge aclk);
        while (scb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] sigma_val,
                                input logic [CFG_W-1:0] mean_val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_SIGMA;
        cfg_wdata <= sigma_val;
        @(posedge aclk);
        cfg_addr  <= REG_MEAN;
        cfg_wdata <= mean_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        scb.set_config(sigma_val, mean_val);
    endtask

    initial begin
        logic [CFG_W-1:0] sigma_set[PHASES];
        logic [CFG_W-1:0] mean_set[PHASES];

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = KIND_DRAW;
        cfg_wr_en    = 1'b0;
        cfg_addr     = REG_SIGMA;
        cfg_wdata    = '0;
        calm         = 1'b0;

        sigma_set = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001,
                      32'h0001_0000, $urandom(), $urandom()};
        mean_set  = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                      32'h0001_0000, $urandom(), $urandom()};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: draws from the zero seed, extreme seeds, reseeds back
        // to back, and draws whose seed field is not zero and must be ignored.
        send_beat(KIND_DRAW, '1);
        send_beat(KIND_DRAW, '0);
        send_beat(KIND_RESEED, '1);
        send_beat(KIND_DRAW, '0);
        send_beat(KIND_DRAW, 31'h2aaa_aaaa);
        send_beat(KIND_RESEED, '0);
        send_beat(KIND_RESEED, 31'd1);
        send_beat(KIND_DRAW, 31'h5555_5555);
        send_beat(KIND_RESEED, 31'h5555_5555);
        send_beat(KIND_DRAW, '0);
        send_beat(KIND_RESEED, 31'h2aaa_aaaa);
        send_beat(KIND_DRAW, '1);
        send_beat(KIND_DRAW, '0);
        send_beat(KIND_DRAW, '0);
        s_tvalid <= 1'b0;
        drain();

        for (int p = 0; p < PHASES; p++) begin
            write_config(sigma_set[p], mean_set[p]);
            calm = (p == 3);
            send_beat(KIND_RESEED, '0);
            send_beat(KIND_DRAW, '0);
            send_beat(KIND_RESEED, '1);
            send_beat(KIND_DRAW, '0);
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                send_random_beat();
            end
            s_tvalid <= 1'b0;
            calm = 1'b0;
            drain();
        end

        if (scb.mismatches == 0 && scb.pending() == 0) begin
            $display("** gaussian_noise_generator: PASSED **");
        end else begin
            $display("** gaussian_noise_generator: FAILED **");
        end
        $finish;
    end

endmodule
